@@ rtl/assert_macros.svh @@
// Assertion macros used by the top level of the ARQ sender.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/arqsw_pkg.sv @@
// Types and codes shared by the ARQ sender modules.
package arqsw_pkg;

	typedef enum logic [1:0] {
		OP_MSG     = 2'd0,
		OP_ACK     = 2'd1,
		OP_TIMEOUT = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		KIND_PKT  = 2'd0,
		KIND_STOP = 2'd1,
		KIND_DROP = 2'd2
	} kind_t;

	localparam int unsigned CFG_W = 4;
	localparam logic [CFG_W-1:0] WINDOW_SIZE_RST = 4'd1;

	typedef struct packed {
		logic msg_end;
		logic ack_end;
		logic fifo_full;
		logic fifo_empty;
		logic room;
		logic win_empty;
		logic ack_ok;
	} status_t;

	typedef struct packed {
		logic msg_byte;
		logic ack_byte;
		logic drop;
		logic copy;
		logic copy_last;
		logic ack_chk;
		logic rd;
		logic rd_win;
		logic emit;
		logic emit_win;
		logic emit_last;
	} cmd_t;

endpackage

@@ rtl/arqsw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module arqsw_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/arqsw_ctrl.sv @@
// Controller state machine of the ARQ sender: sequences copy, check and emit.
module arqsw_ctrl #(
	parameter int unsigned PAYLOAD_BYTES = 20
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [1:0]                opcode,
	output logic                      busy,
	input  arqsw_pkg::status_t        st,
	output arqsw_pkg::cmd_t           cmd,
	output logic [((PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1)-1:0] idx,
	output logic [((PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1)-1:0] idx_s1
);

	localparam int unsigned IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
	localparam int unsigned CNT_W = $clog2(PAYLOAD_BYTES + 1);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_COPY   = 6'b000010,
		S_ROOM   = 6'b000100,
		S_ACK    = 6'b001000,
		S_SEND   = 6'b010000,
		S_RESEND = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic [CNT_W-1:0] idx_q, idx_d;
	logic rd_s1;
	logic win_s1;
	logic last_s1;

	assign idx = idx_q[IDX_W-1:0];
	assign last_s1 = (idx_s1 == IDX_W'(PAYLOAD_BYTES - 1));

	always_comb begin
		cmd = '0;
		state_d = state_q;
		idx_d = idx_q;
		busy = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (opcode)
						arqsw_pkg::OP_MSG: begin
							cmd.msg_byte = 1'b1;
							if (st.msg_end) begin
								if (st.fifo_full) begin
									cmd.drop = 1'b1;
								end else begin
									state_d = S_COPY;
									idx_d = '0;
								end
							end
						end
						arqsw_pkg::OP_ACK: begin
							cmd.ack_byte = 1'b1;
							if (st.ack_end) begin
								state_d = S_ACK;
							end
						end
						arqsw_pkg::OP_TIMEOUT: begin
							if (!st.win_empty) begin
								state_d = S_RESEND;
								idx_d = '0;
							end
						end
						default: ;
					endcase
				end
			end
			S_COPY: begin
				cmd.copy = 1'b1;
				if (idx_q == CNT_W'(PAYLOAD_BYTES - 1)) begin
					cmd.copy_last = 1'b1;
					state_d = S_ROOM;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			S_ROOM: begin
				if (st.room && !st.fifo_empty) begin
					state_d = S_SEND;
					idx_d = '0;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_ACK: begin
				cmd.ack_chk = 1'b1;
				state_d = st.ack_ok ? S_ROOM : S_IDLE;
			end
			S_SEND, S_RESEND: begin
				if (idx_q < CNT_W'(PAYLOAD_BYTES)) begin
					cmd.rd = 1'b1;
					cmd.rd_win = (state_q == S_RESEND);
					idx_d = idx_q + 1'b1;
				end
				if (rd_s1 && last_s1) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		cmd.emit = rd_s1;
		cmd.emit_win = win_s1;
		cmd.emit_last = rd_s1 && last_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			rd_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
			rd_s1 <= cmd.rd;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q[IDX_W-1:0];
		win_s1 <= cmd.rd_win;
	end

endmodule

@@ rtl/arqsw_dp.sv @@
// Datapath of the ARQ sender: assembly, waiting queue, window and result register.
module arqsw_dp #(
	parameter int unsigned QUEUE_DEPTH   = 64,
	parameter int unsigned WINDOW_MAX    = 8,
	parameter int unsigned PAYLOAD_BYTES = 20
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  arqsw_pkg::cmd_t           cmd,
	output arqsw_pkg::status_t        st,
	input  logic [((PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1)-1:0] idx,
	input  logic [((PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1)-1:0] idx_s1,
	input  logic signed [7:0]         data_byte,
	input  logic                      last_byte,
	input  logic [31:0]               pkt_seq,
	input  logic [31:0]               pkt_ack,
	input  logic [31:0]               pkt_checksum,
	input  logic                      cfg_we,
	input  logic [arqsw_pkg::CFG_W-1:0] cfg_data,
	output logic                      result_strobe,
	output logic [1:0]                out_kind,
	output logic [31:0]               out_seq,
	output logic                      out_ack,
	output logic [31:0]               out_checksum,
	output logic signed [7:0]         out_byte,
	output logic                      out_last
);

	localparam int unsigned IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
	localparam int unsigned QA_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned QC_W = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned PA_DEPTH = QUEUE_DEPTH * PAYLOAD_BYTES;
	localparam int unsigned PA_W = (PA_DEPTH > 1) ? $clog2(PA_DEPTH) : 1;
	localparam int unsigned WA_DEPTH = WINDOW_MAX * PAYLOAD_BYTES;
	localparam int unsigned WA_W = (WA_DEPTH > 1) ? $clog2(WA_DEPTH) : 1;
	localparam int unsigned WS_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int unsigned WC_W = $clog2(WINDOW_MAX + 1);
	localparam int unsigned CMP_W = (WC_W > arqsw_pkg::CFG_W) ? WC_W : arqsw_pkg::CFG_W;

	logic [arqsw_pkg::CFG_W-1:0] window_size_q;

	// Message assembly.
	logic [7:0] msg_buf_q [PAYLOAD_BYTES];
	logic [31:0] run_sum_q;
	logic [IDX_W-1:0] byte_idx_q;
	logic [31:0] next_seq_q;
	logic [31:0] byte_sext;

	// Ack request assembly.
	logic [31:0] ack_sum_q;
	logic [IDX_W-1:0] ack_idx_q;
	logic [31:0] ack_seq_q, ack_ack_q, ack_cks_q;

	// Waiting queue pointers.
	logic [QA_W-1:0] q_head_q, q_tail_q;
	logic [QC_W-1:0] q_count_q;

	// Window bookkeeping: logical positions map to physical payload slots.
	logic [31:0] win_seq_q [WINDOW_MAX];
	logic [31:0] win_cks_q [WINDOW_MAX];
	logic [WS_W-1:0] win_slot_q [WINDOW_MAX];
	logic [WC_W-1:0] win_count_q;
	logic [WS_W-1:0] new_slot;
	logic [WS_W-1:0] freed_slot;
	logic [WINDOW_MAX-1:0] shift;
	logic found;
	logic ack_ok;
	logic commit;

	logic [7:0] pay_rdata, win_rdata;
	logic [63:0] hdr_rdata;
	logic [PA_W-1:0] pay_waddr, pay_raddr;
	logic [WA_W-1:0] win_waddr, win_raddr;

	assign byte_sext = {{24{data_byte[7]}}, data_byte};
	assign commit = cmd.emit_last && !cmd.emit_win;
	assign new_slot = win_slot_q[win_count_q[WS_W-1:0]];

	assign pay_waddr = PA_W'(32'(q_tail_q) * PAYLOAD_BYTES + 32'(idx));
	assign pay_raddr = PA_W'(32'(q_head_q) * PAYLOAD_BYTES + 32'(idx));
	assign win_waddr = WA_W'(32'(new_slot) * PAYLOAD_BYTES + 32'(idx_s1));
	assign win_raddr = WA_W'(32'(win_slot_q[0]) * PAYLOAD_BYTES + 32'(idx));

	arqsw_ram #(.WIDTH(8), .DEPTH(PA_DEPTH)) u_wait_pay (
		.clk   (clk),
		.we    (cmd.copy),
		.waddr (pay_waddr),
		.wdata (msg_buf_q[idx]),
		.raddr (pay_raddr),
		.rdata (pay_rdata)
	);

	arqsw_ram #(.WIDTH(64), .DEPTH(QUEUE_DEPTH)) u_wait_hdr (
		.clk   (clk),
		.we    (cmd.copy_last),
		.waddr (q_tail_q),
		.wdata ({next_seq_q, next_seq_q + 32'd1 + run_sum_q}),
		.raddr (q_head_q),
		.rdata (hdr_rdata)
	);

	arqsw_ram #(.WIDTH(8), .DEPTH(WA_DEPTH)) u_win_pay (
		.clk   (clk),
		.we    (cmd.emit && !cmd.emit_win),
		.waddr (win_waddr),
		.wdata (pay_rdata),
		.raddr (win_raddr),
		.rdata (win_rdata)
	);

	// Oldest live entry whose seq matches; positions from it on shift down.
	always_comb begin
		found = 1'b0;
		freed_slot = '0;
		shift = '0;
		for (int i = 0; i < WINDOW_MAX; i++) begin
			if (!found && (WC_W'(i) < win_count_q) && (win_seq_q[i] == ack_seq_q)) begin
				freed_slot = win_slot_q[i];
				found = 1'b1;
			end
			shift[i] = found;
		end
		ack_ok = found && (ack_ack_q == 32'd1) &&
			(ack_cks_q == ack_seq_q + ack_ack_q + ack_sum_q);
	end

	always_comb begin
		st.msg_end = last_byte || (byte_idx_q == IDX_W'(PAYLOAD_BYTES - 1));
		st.ack_end = last_byte || (ack_idx_q == IDX_W'(PAYLOAD_BYTES - 1));
		st.fifo_full = (q_count_q == QC_W'(QUEUE_DEPTH));
		st.fifo_empty = (q_count_q == '0);
		st.room = (CMP_W'(win_count_q) < CMP_W'(WINDOW_MAX)) &&
			(CMP_W'(win_count_q) < CMP_W'(window_size_q));
		st.win_empty = (win_count_q == '0);
		st.ack_ok = ack_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= arqsw_pkg::WINDOW_SIZE_RST;
		end else if (cfg_we) begin
			window_size_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PAYLOAD_BYTES; i++) begin
				msg_buf_q[i] <= '0;
			end
			run_sum_q <= '0;
			byte_idx_q <= '0;
			next_seq_q <= '0;
		end else begin
			if (cmd.drop) begin
				for (int i = 0; i < PAYLOAD_BYTES; i++) begin
					msg_buf_q[i] <= '0;
				end
				run_sum_q <= '0;
				byte_idx_q <= '0;
			end else if (cmd.msg_byte) begin
				msg_buf_q[byte_idx_q] <= data_byte;
				run_sum_q <= run_sum_q + byte_sext;
				byte_idx_q <= st.msg_end ? '0 : byte_idx_q + 1'b1;
			end
			// The buffer is cleared as it is copied so a short message pads with zeros.
			if (cmd.copy) begin
				msg_buf_q[idx] <= '0;
			end
			if (cmd.copy_last) begin
				run_sum_q <= '0;
				next_seq_q <= next_seq_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_sum_q <= '0;
			ack_idx_q <= '0;
		end else begin
			if (cmd.ack_byte) begin
				ack_sum_q <= ack_sum_q + byte_sext;
				ack_idx_q <= st.ack_end ? '0 : ack_idx_q + 1'b1;
			end
			if (cmd.ack_chk) begin
				ack_sum_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ack_byte && st.ack_end) begin
			ack_seq_q <= pkt_seq;
			ack_ack_q <= pkt_ack;
			ack_cks_q <= pkt_checksum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_head_q <= '0;
			q_tail_q <= '0;
			q_count_q <= '0;
		end else begin
			if (cmd.copy_last) begin
				q_tail_q <= (q_tail_q == QA_W'(QUEUE_DEPTH - 1)) ? '0 : q_tail_q + 1'b1;
				q_count_q <= q_count_q + 1'b1;
			end
			if (commit) begin
				q_head_q <= (q_head_q == QA_W'(QUEUE_DEPTH - 1)) ? '0 : q_head_q + 1'b1;
				q_count_q <= q_count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_MAX; i++) begin
				win_slot_q[i] <= WS_W'(i);
			end
			win_count_q <= '0;
		end else begin
			if (commit) begin
				win_count_q <= win_count_q + 1'b1;
			end
			if (cmd.ack_chk && ack_ok) begin
				for (int i = 0; i < WINDOW_MAX - 1; i++) begin
					if (shift[i]) begin
						win_slot_q[i] <= win_slot_q[i + 1];
					end
				end
				win_slot_q[WINDOW_MAX - 1] <= freed_slot;
				win_count_q <= win_count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			win_seq_q[win_count_q[WS_W-1:0]] <= hdr_rdata[63:32];
			win_cks_q[win_count_q[WS_W-1:0]] <= hdr_rdata[31:0];
		end
		if (cmd.ack_chk && ack_ok) begin
			for (int i = 0; i < WINDOW_MAX - 1; i++) begin
				if (shift[i]) begin
					win_seq_q[i] <= win_seq_q[i + 1];
					win_cks_q[i] <= win_cks_q[i + 1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= cmd.drop || (cmd.ack_chk && ack_ok) || cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.drop) begin
			out_kind <= arqsw_pkg::KIND_DROP;
			out_seq <= '0;
			out_ack <= 1'b0;
			out_checksum <= '0;
			out_byte <= '0;
			out_last <= 1'b0;
		end else if (cmd.ack_chk && ack_ok) begin
			out_kind <= arqsw_pkg::KIND_STOP;
			out_seq <= ack_seq_q;
			out_ack <= 1'b0;
			out_checksum <= '0;
			out_byte <= '0;
			out_last <= 1'b0;
		end else if (cmd.emit) begin
			out_kind <= arqsw_pkg::KIND_PKT;
			out_seq <= cmd.emit_win ? win_seq_q[0] : hdr_rdata[63:32];
			out_ack <= 1'b1;
			out_checksum <= cmd.emit_win ? win_cks_q[0] : hdr_rdata[31:0];
			out_byte <= cmd.emit_win ? win_rdata : pay_rdata;
			out_last <= cmd.emit_last;
		end
	end

endmodule

@@ rtl/arq_sender_window_core.sv @@
// Top level of the ARQ sender with a sliding window of outstanding packets.
//
// An input request is taken when start is high and busy is low. A message byte
// or an ack byte that does not end its packet leaves busy low.
// The byte that ends a message starts a copy of PAYLOAD_BYTES bytes into the
// waiting queue and, when the window has room, a send; the bytes leave on
// consecutive cycles, one per cycle, each marked by result_strobe for one cycle.
// A full queue gives one drop result in the next cycle instead.
// The byte that ends an ack packet is followed by a check; a match gives a stop
// result and possibly a send as above. A timeout resends the oldest outstanding
// packet. The payload memories are read one byte per cycle through their
// single read port, which sets the per-byte emit rate.
// The receiver cannot stall: every result is valid for exactly one cycle.
// Reset empties the queue and window and sets the window size to one.
// cfg_we writes the window size; write it only while busy is low.
module arq_sender_window_core #(
	parameter int unsigned QUEUE_DEPTH   = 64,
	parameter int unsigned WINDOW_MAX    = 8,
	parameter int unsigned PAYLOAD_BYTES = 20
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  opcode,
	input  logic signed [7:0]           data_byte,
	input  logic                        last_byte,
	input  logic [31:0]                 pkt_seq,
	input  logic [31:0]                 pkt_ack,
	input  logic [31:0]                 pkt_checksum,
	input  logic                        cfg_we,
	input  logic [arqsw_pkg::CFG_W-1:0] cfg_data,
	output logic                        result_strobe,
	output logic [1:0]                  out_kind,
	output logic [31:0]                 out_seq,
	output logic                        out_ack,
	output logic [31:0]                 out_checksum,
	output logic signed [7:0]           out_byte,
	output logic                        out_last
);

	`include "assert_macros.svh"

	localparam int unsigned IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

	arqsw_pkg::cmd_t    cmd;
	arqsw_pkg::status_t st;
	logic [IDX_W-1:0]   idx, idx_s1;

	arqsw_ctrl #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.busy   (busy),
		.st     (st),
		.cmd    (cmd),
		.idx    (idx),
		.idx_s1 (idx_s1)
	);

	arqsw_dp #(
		.QUEUE_DEPTH   (QUEUE_DEPTH),
		.WINDOW_MAX    (WINDOW_MAX),
		.PAYLOAD_BYTES (PAYLOAD_BYTES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.idx           (idx),
		.idx_s1        (idx_s1),
		.data_byte     (data_byte),
		.last_byte     (last_byte),
		.pkt_seq       (pkt_seq),
		.pkt_ack       (pkt_ack),
		.pkt_checksum  (pkt_checksum),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.result_strobe (result_strobe),
		.out_kind      (out_kind),
		.out_seq       (out_seq),
		.out_ack       (out_ack),
		.out_checksum  (out_checksum),
		.out_byte      (out_byte),
		.out_last      (out_last)
	);

	// A drop result follows the accepted request that ended the message.
	`ASSERT_IMPLIES(a_drop_after_accept, clk, arst_n, result_strobe && out_kind == arqsw_pkg::KIND_DROP, $past(start && !busy))
	// Only packet bytes can close a packet.
	`ASSERT_IMPLIES(a_last_is_pkt, clk, arst_n, result_strobe && out_last, out_kind == arqsw_pkg::KIND_PKT)
	// Packet bytes leave back to back with a steady header.
	`ASSERT_NEXT(a_pkt_contiguous, clk, arst_n, result_strobe && out_kind == arqsw_pkg::KIND_PKT && !out_last, result_strobe && out_kind == arqsw_pkg::KIND_PKT && $stable(out_seq))

endmodule

@@ dv/arq_sender_window_checker.sv @@
// Checker for the ARQ sender: predicts every result from accepted requests and compares.
module arq_sender_window_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  logic [1:0]                    opcode,
	input  logic signed [7:0]             data_byte,
	input  logic                          last_byte,
	input  logic [31:0]                   pkt_seq,
	input  logic [31:0]                   pkt_ack,
	input  logic [31:0]                   pkt_checksum,
	input  logic                          cfg_we,
	input  logic [arqsw_pkg::CFG_W-1:0]   cfg_data,
	input  logic                          result_strobe,
	input  logic [1:0]                    out_kind,
	input  logic [31:0]                   out_seq,
	input  logic                          out_ack,
	input  logic [31:0]                   out_checksum,
	input  logic signed [7:0]             out_byte,
	input  logic                          out_last,
	output int                            fail_count,
	output int                            pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NBYTES = 20;
	localparam int QDEPTH = 64;
	localparam int WMAX   = 8;

	typedef struct packed {
		logic [31:0]         seq;
		logic [31:0]         cks;
		logic [NBYTES*8-1:0] pay;
	} packet_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] seq;
		logic        ack;
		logic [31:0] cks;
		logic [7:0]  data;
		logic        last;
	} result_t;

	packet_t waiting_q[$];
	packet_t window_q[$];
	result_t due_q[$];
	logic [NBYTES*8-1:0] msg_bytes;
	logic [31:0] msg_sum, ack_sum, next_seq;
	int msg_idx, ack_idx;
	logic [arqsw_pkg::CFG_W-1:0] win_size;

	assign pending = due_q.size();

	function automatic logic [31:0] sext(logic [7:0] b);
		return {{24{b[7]}}, b};
	endfunction

	task automatic queue_result(result_t r);
		due_q = {due_q, r};
	endtask

	task automatic emit_packet(packet_t p);
		result_t r;
		for (int i = 0; i < NBYTES; i++) begin
			r = '{arqsw_pkg::KIND_PKT, p.seq, 1'b1, p.cks, p.pay[i*8 +: 8], i == NBYTES - 1};
			queue_result(r);
		end
	endtask

	task automatic send_waiting();
		int w;
		packet_t p;
		w = (win_size > WMAX) ? WMAX : win_size;
		if (waiting_q.size() > 0 && window_q.size() < w) begin
			p = waiting_q.pop_front();
			window_q = {window_q, p};
			emit_packet(p);
		end
	endtask

	task automatic predict_request();
		packet_t p;
		result_t r;
		int hit;
		case (opcode)
			arqsw_pkg::OP_MSG: begin
				if (msg_idx < NBYTES)
					msg_bytes[msg_idx*8 +: 8] = data_byte;
				msg_sum += sext(data_byte);
				msg_idx++;
				if (last_byte || msg_idx >= NBYTES) begin
					if (waiting_q.size() >= QDEPTH) begin
						r = '{arqsw_pkg::KIND_DROP, 32'd0, 1'b0, 32'd0, 8'd0, 1'b0};
						queue_result(r);
					end else begin
						p.seq = next_seq;
						p.cks = next_seq + 32'd1 + msg_sum;
						p.pay = msg_bytes;
						waiting_q = {waiting_q, p};
						next_seq++;
						send_waiting();
					end
					msg_bytes = '0;
					msg_sum = '0;
					msg_idx = 0;
				end
			end
			arqsw_pkg::OP_ACK: begin
				ack_sum += sext(data_byte);
				ack_idx++;
				if (last_byte || ack_idx >= NBYTES) begin
					hit = -1;
					for (int i = 0; i < window_q.size(); i++)
						if (hit < 0 && window_q[i].seq == pkt_seq)
							hit = i;
					if (pkt_checksum == pkt_seq + pkt_ack + ack_sum && pkt_ack == 32'd1
							&& hit >= 0) begin
						r = '{arqsw_pkg::KIND_STOP, pkt_seq, 1'b0, 32'd0, 8'd0, 1'b0};
						queue_result(r);
						window_q.delete(hit);
						send_waiting();
					end
					ack_sum = '0;
					ack_idx = 0;
				end
			end
			arqsw_pkg::OP_TIMEOUT: begin
				if (window_q.size() > 0)
					emit_packet(window_q[0]);
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t got, want;
		if (!arst_n) begin
			waiting_q.delete();
			window_q.delete();
			due_q.delete();
			msg_bytes = '0;
			msg_sum = '0;
			ack_sum = '0;
			next_seq = '0;
			msg_idx = 0;
			ack_idx = 0;
			win_size = arqsw_pkg::WINDOW_SIZE_RST;
			fail_count = 0;
		end else begin
			// Results at this edge belong to requests taken at earlier edges.
			if (result_strobe) begin
				got = '{out_kind, out_seq, out_ack, out_checksum, out_byte, out_last};
				if (due_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: expected none, got kind=%0d seq=%h",
							out_kind, out_seq);
				end else begin
					want = due_q.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"mismatch: expected kind=%0d seq=%h ack=%b cks=%h ",
								"byte=%h last=%b, got kind=%0d seq=%h ack=%b cks=%h ",
								"byte=%h last=%b"},
								want.kind, want.seq, want.ack, want.cks, want.data,
								want.last, got.kind, got.seq, got.ack, got.cks,
								got.data, got.last);
					end
				end
			end
			if (cfg_we)
				win_size = cfg_data;
			if (start && !busy)
				predict_request();
		end
	end
endmodule

@@ dv/testbench.sv @@
// Top of the ARQ sender testbench: clock, reset, request stimulus and the verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [1:0] opcode = arqsw_pkg::OP_MSG;
	logic signed [7:0] data_byte = '0;
	logic last_byte = 1'b0;
	logic [31:0] pkt_seq = '0, pkt_ack = '0, pkt_checksum = '0;
	logic cfg_we = 1'b0;
	logic [arqsw_pkg::CFG_W-1:0] cfg_data = '0;
	logic result_strobe;
	logic [1:0] out_kind;
	logic [31:0] out_seq, out_checksum;
	logic out_ack, out_last;
	logic signed [7:0] out_byte;
	int fail_count, pending;

	int items = 0;
	int burst_left = 0;
	int quiet_cycles = 0;
	logic [31:0] sent_seqs[$];

	localparam int WATCHDOG = 5000;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	arq_sender_window_core dut (.*);

	arq_sender_window_checker chk (.*);

	// Remember sequence numbers seen on the link so that acks can name them.
	always @(posedge clk) begin
		if (result_strobe && out_kind == arqsw_pkg::KIND_PKT && out_last) begin
			sent_seqs = {sent_seqs, out_seq};
			if (sent_seqs.size() > 16)
				void'(sent_seqs.pop_front());
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || result_strobe || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG) begin
			$display("watchdog expired");
			$display("FAIL arq_sender_window_core");
			$finish;
		end
	end

	task automatic request(logic [1:0] op, logic [7:0] b, logic lst, logic [31:0] s,
			logic [31:0] a, logic [31:0] c);
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 20);
		end
		burst_left--;
		start <= 1'b1;
		opcode <= op;
		data_byte <= b;
		last_byte <= lst;
		pkt_seq <= s;
		pkt_ack <= a;
		pkt_checksum <= c;
		do @(posedge clk); while (busy);
		items++;
	endtask

	// fill: 0 random bytes, 1 all -128, 2 all 127.
	task automatic send_message(int len, logic use_last, int fill);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			b = (fill == 1) ? 8'h80 : (fill == 2) ? 8'h7f : 8'($urandom);
			request(arqsw_pkg::OP_MSG, b, use_last && i == len - 1, $urandom, $urandom,
				$urandom);
		end
	endtask

	// bad: 0 valid, 1 wrong checksum, 2 ack field not one.
	task automatic send_ack(logic [31:0] s, int len, logic use_last, int bad);
		logic [7:0] bytes[20];
		logic [31:0] sum, a;
		sum = '0;
		for (int i = 0; i < len; i++) begin
			bytes[i] = 8'($urandom);
			sum += {{24{bytes[i][7]}}, bytes[i]};
		end
		a = (bad == 2) ? ($urandom | 32'h2) : 32'd1;
		sum = s + a + sum + ((bad == 1) ? 32'($urandom_range(1, 32'hffff)) : 32'd0);
		for (int i = 0; i < len; i++)
			request(arqsw_pkg::OP_ACK, bytes[i], use_last && i == len - 1, s, a, sum);
	endtask

	task automatic ack_some_sent(int bad);
		logic [31:0] s;
		int len;
		s = (sent_seqs.size() > 0) ? sent_seqs[$urandom_range(0, sent_seqs.size() - 1)]
			: 32'd0;
		len = $urandom_range(1, 20);
		send_ack(s, len, len < 20 || $urandom_range(0, 1), bad);
	endtask

	task automatic settle_and_write(logic [arqsw_pkg::CFG_W-1:0] value);
		start <= 1'b0;
		do @(posedge clk); while (pending != 0 || busy);
		repeat (40) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		burst_left = 0;
	endtask

	task automatic random_phase(int count);
		int pick, len;
		int stop_at;
		stop_at = items + count;
		while (items < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				len = $urandom_range(1, 20);
				send_message(len, len < 20 || $urandom_range(0, 1), 0);
			end else if (pick < 75) begin
				ack_some_sent(0);
			end else if (pick < 82) begin
				ack_some_sent($urandom_range(1, 2));
			end else if (pick < 90) begin
				request(arqsw_pkg::OP_TIMEOUT, 8'($urandom), 1'($urandom), $urandom,
					$urandom, $urandom);
			end else if (pick < 96) begin
				send_ack($urandom, $urandom_range(1, 3), 1'b1, $urandom_range(0, 2));
			end else begin
				request(OP_UNUSED, 8'($urandom), 1'($urandom), $urandom, $urandom,
					$urandom);
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: full-length message of extreme bytes, short and unmarked long ones.
		send_message(20, 1'b1, 1);
		send_message(20, 1'b0, 2);
		send_message(1, 1'b1, 0);
		request(arqsw_pkg::OP_TIMEOUT, 8'h00, 1'b0, '0, '0, '0);
		send_ack(32'd0, 20, 1'b1, 1);
		send_ack(32'd0, 2, 1'b1, 2);
		send_ack(32'd0, 3, 1'b1, 0);
		send_ack(32'd7, 1, 1'b1, 0);
		send_ack(32'd1, 20, 1'b0, 0);
		send_ack(32'd2, 1, 1'b1, 0);
		request(arqsw_pkg::OP_TIMEOUT, 8'hff, 1'b1, '1, '1, '1);
		request(OP_UNUSED, 8'h55, 1'b1, '0, '0, '0);

		// Window zero: the queue fills without sending, then messages are dropped.
		settle_and_write(4'd0);
		for (int i = 0; i < 66; i++)
			send_message(1, 1'b1, 0);
		settle_and_write(4'd8);
		random_phase(50);
		settle_and_write(4'd15);
		random_phase(35);
		settle_and_write(4'd3);
		random_phase(25);
		settle_and_write(4'd1);
		random_phase(15);

		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (50) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("PASS arq_sender_window_core");
		else
			$display("FAIL arq_sender_window_core");
		$finish;
	end
endmodule

@@ files.f @@
+incdir+rtl
rtl/arqsw_pkg.sv
rtl/arqsw_ram.sv
rtl/arqsw_ctrl.sv
rtl/arqsw_dp.sv
rtl/arq_sender_window_core.sv
dv/arq_sender_window_checker.sv
dv/testbench.sv
